/* hw/rtl/mbrsp_pkg.sv */
// Shared types, codes and constants for the Modbus TCP read-response checker.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package mbrsp_pkg;

	localparam int MAX_REGISTERS = 125;
	localparam int FIFO_DEPTH    = 4;
	localparam int PTR_W         = $clog2(FIFO_DEPTH);
	localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int OUT_TDATA_W   = 32;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_TRANSACTION = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNIT        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUANTITY    = 3'd3;

	// frame byte positions
	localparam logic [8:0] POS_TID_LO = 9'd1;
	localparam logic [8:0] POS_PID_LO = 9'd3;
	localparam logic [8:0] POS_LEN_LO = 9'd5;
	localparam logic [8:0] POS_UNIT   = 9'd6;
	localparam logic [8:0] POS_FUNC   = 9'd7;
	localparam logic [8:0] POS_COUNT  = 9'd8;
	localparam logic [8:0] POS_MIN    = 9'd9;
	localparam logic [8:0] POS_DATA   = 9'd10;
	localparam logic [8:0] POS_SAT    = 9'd511;

	// item kinds
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// frame status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_SHORT       = 3'd1;
	localparam logic [2:0] ST_PROTOCOL    = 3'd2;
	localparam logic [2:0] ST_LENGTH      = 3'd3;
	localparam logic [2:0] ST_TRANSACTION = 3'd4;
	localparam logic [2:0] ST_UNIT        = 3'd5;
	localparam logic [2:0] ST_FUNCTION    = 3'd6;
	localparam logic [2:0] ST_BYTE_COUNT  = 3'd7;

	// exception kinds
	localparam logic [2:0] EXC_NONE  = 3'd0;
	localparam logic [2:0] EXC_OTHER = 3'd5;

	typedef struct packed {
		logic [15:0] transaction;
		logic [7:0]  unit;
		logic [6:0]  function_code;
		logic [6:0]  quantity;
	} cfg_t;

	typedef struct packed {
		logic        item_kind;
		logic [6:0]  reg_index;
		logic [15:0] reg_value;
		logic [2:0]  frame_status;
		logic [2:0]  exception_kind;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} core_out_t;

	function automatic logic [2:0] exception_map(input logic [7:0] code);
		logic [2:0] k;
		k = EXC_OTHER;
		if (code inside {[8'd1:8'd4]}) begin
			k = code[2:0];
		end
		return k;
	endfunction

endpackage

/* hw/rtl/mbrsp_core.sv */
// Per-byte frame checker: frame state registers and the decode of one byte.
// Depends on mbrsp_pkg.
`timescale 1ns / 1ps

module mbrsp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         in_byte,
	input  logic               in_end,
	input  mbrsp_pkg::cfg_t    cfg,
	output mbrsp_pkg::core_out_t out
);
	import mbrsp_pkg::*;

	logic [8:0]  pos_q, pos_n;
	logic [2:0]  herr_q, herr_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  shift_q;
	logic [7:0]  func_q, func_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [6:0]  wc_q, wc_n;
	logic        word;
	logic [2:0]  st;
	logic [2:0]  exc;
	result_t     wres, sres;

	always_comb begin
		herr_n = herr_q;
		len_n  = len_q;
		func_n = func_q;
		cnt_n  = cnt_q;
		wc_n   = wc_q;
		word   = 1'b0;
		case (pos_q)
			POS_TID_LO: begin
				if ({shift_q, in_byte} != cfg.transaction) herr_n = ST_TRANSACTION;
			end
			POS_PID_LO: begin
				if (shift_q != 8'd0 || in_byte != 8'd0) herr_n = ST_PROTOCOL;
			end
			POS_LEN_LO: begin
				len_n = {shift_q, in_byte};
			end
			POS_UNIT: begin
				if (herr_q == ST_OK && in_byte != cfg.unit) herr_n = ST_UNIT;
			end
			POS_FUNC: begin
				func_n = in_byte;
			end
			POS_COUNT: begin
				cnt_n = in_byte;
			end
			default: begin
				if (pos_q >= POS_DATA && pos_q < POS_SAT && !pos_q[0] && !func_q[7] &&
				    wc_q < cfg.quantity && wc_q < 7'(MAX_REGISTERS)) begin
					word = 1'b1;
					wc_n = wc_q + 7'd1;
				end
			end
		endcase
		pos_n = (pos_q != POS_SAT) ? pos_q + 9'd1 : pos_q;
	end

	// final status from the updated frame state
	always_comb begin
		st  = ST_OK;
		exc = EXC_NONE;
		if (pos_n < POS_MIN) begin
			st = ST_SHORT;
		end else if (herr_n != ST_OK) begin
			st = herr_n;
		end else if (pos_n == POS_SAT || ({1'b0, len_n} + 17'd6) != {8'd0, pos_n}) begin
			st = ST_LENGTH;
		end else if (func_n[7]) begin
			if (func_n[6:0] != cfg.function_code) st = ST_FUNCTION;
			else exc = exception_map(cnt_n);
		end else if (func_n != {1'b0, cfg.function_code}) begin
			st = ST_FUNCTION;
		end else if (cnt_n != {cfg.quantity, 1'b0}) begin
			st = ST_BYTE_COUNT;
		end else if (({2'd0, cnt_n} + 10'd9) != {1'b0, pos_n}) begin
			st = ST_LENGTH;
		end
	end

	always_comb begin
		wres.item_kind      = KIND_WORD;
		wres.reg_index      = wc_q;
		wres.reg_value      = {shift_q, in_byte};
		wres.frame_status   = ST_OK;
		wres.exception_kind = EXC_NONE;
		wres.run_last       = !in_end;
		sres.item_kind      = KIND_STATUS;
		sres.reg_index      = 7'd0;
		sres.reg_value      = 16'd0;
		sres.frame_status   = st;
		sres.exception_kind = exc;
		sres.run_last       = 1'b1;
		out.r1 = sres;
		if (word) begin
			out.r0 = wres;
			out.n  = in_end ? 2'd2 : 2'd1;
		end else begin
			out.r0 = sres;
			out.n  = in_end ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			herr_q  <= ST_OK;
			len_q   <= '0;
			shift_q <= '0;
			func_q  <= '0;
			cnt_q   <= '0;
			wc_q    <= '0;
		end else if (go) begin
			if (in_end) begin
				pos_q   <= '0;
				herr_q  <= ST_OK;
				len_q   <= '0;
				shift_q <= '0;
				func_q  <= '0;
				cnt_q   <= '0;
				wc_q    <= '0;
			end else begin
				pos_q   <= pos_n;
				herr_q  <= herr_n;
				len_q   <= len_n;
				shift_q <= in_byte;
				func_q  <= func_n;
				cnt_q   <= cnt_n;
				wc_q    <= wc_n;
			end
		end
	end

	a_word_in_quantity: assert property (@(posedge clk) disable iff (!arst_n)
		(out.n != 2'd0 && out.r0.item_kind == KIND_WORD) |-> (out.r0.reg_index < cfg.quantity))
		else $error("word index beyond requested quantity");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go && in_end) |=> (pos_q == 9'd0 && wc_q == 7'd0))
		else $error("frame state not cleared after frame end");

endmodule

/* hw/rtl/mbrsp_result_fifo.sv */
// Small result queue: takes up to two result items per cycle, gives one.
// Depends on mbrsp_pkg.
`timescale 1ns / 1ps

module mbrsp_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  mbrsp_pkg::result_t  in0,
	input  mbrsp_pkg::result_t  in1,
	input  logic [1:0]          req_n,
	output logic                fits,
	input  logic                pop,
	output logic                head_valid,
	output mbrsp_pkg::result_t  head
);
	import mbrsp_pkg::*;

	result_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W:0]     need;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign need       = {1'b0, cnt_q} + (CNT_W+1)'(req_n);
	assign fits       = need <= (CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(pop);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= in0;
		if (push_n == 2'd2) mem_q[wr_ptr_q + PTR_W'(1)] <= in1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (fits && push_n == req_n))
		else $error("push without room");

endmodule

/* hw/rtl/modbus_tcp_read_response_check.sv */
// Top level of the Modbus TCP read-registers response checker.
// Depends on mbrsp_pkg, mbrsp_core and mbrsp_result_fifo.
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           tdata data_byte, tlast frame_end
//  m_axis    out        tvalid/tready           tdata index/value/status/exception,
//                                               tuser item_kind, tlast run_last
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  One byte per cycle while the queue has room: input register, one pass of decode, result queue.
//  A frame-end byte that also completes a word gives two items; the 4-entry queue
//  absorbs the extra one, and the input stalls only when the queue lacks room.
//  Reset clears the frame state and loads the default configuration; cfg_ready is
//  always high. An accepted byte goes through the input register and the queue.

module modbus_tcp_read_response_check (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [7:0]                              s_axis_tdata,  // [7:0] data_byte
	input  logic                                    s_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// [6:0] reg_index, [22:7] reg_value, [25:23] frame_status,
	// [28:26] exception_kind, [31:29] zero
	output logic [mbrsp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	output logic                                    m_axis_tuser,  // [0] item_kind
	output logic                                    m_axis_tlast,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [mbrsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [mbrsp_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import mbrsp_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        go;
	logic        fits;
	logic        pop;
	logic [1:0]  push_n;
	core_out_t   core_out;
	result_t     head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transaction   <= 16'd0;
			cfg_q.unit          <= 8'd0;
			cfg_q.function_code <= 7'd3;
			cfg_q.quantity      <= 7'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TRANSACTION: cfg_q.transaction   <= cfg_data;
				CFG_UNIT:        cfg_q.unit          <= cfg_data[7:0];
				CFG_FUNCTION:    cfg_q.function_code <= cfg_data[6:0];
				CFG_QUANTITY:    cfg_q.quantity      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input register: advance when empty or when its byte is processed
	assign go            = valid_s1 && fits;
	assign s_axis_tready = !valid_s1 || fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	mbrsp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.in_byte (byte_s1),
		.in_end  (end_s1),
		.cfg     (cfg_q),
		.out     (core_out)
	);

	assign push_n = go ? core_out.n : 2'd0;
	assign pop    = m_axis_tvalid && m_axis_tready;

	mbrsp_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.in0        (core_out.r0),
		.in1        (core_out.r1),
		.req_n      (core_out.n),
		.fits       (fits),
		.pop        (pop),
		.head_valid (m_axis_tvalid),
		.head       (head)
	);

	assign m_axis_tdata = {3'd0, head.exception_kind, head.frame_status,
	                       head.reg_value, head.reg_index};
	assign m_axis_tuser = head.item_kind;
	assign m_axis_tlast = head.run_last;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_STATUS) |-> m_axis_tlast)
		else $error("status item without run end");

endmodule
